// ===== sv/xmbr_pkg.sv =====
package xmbr_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int ADDR_BITS   = 16;
    localparam int FPOS_BITS   = $clog2(BLOCK_BYTES + 4);

    // frame positions: 0 = frame start, 1 = block number, 2 = inverted number,
    // 3 .. BLOCK_BYTES+2 = data, BLOCK_BYTES+3 = checksum
    localparam logic [FPOS_BITS-1:0] POS_START = FPOS_BITS'(0);
    localparam logic [FPOS_BITS-1:0] POS_NUM   = FPOS_BITS'(1);
    localparam logic [FPOS_BITS-1:0] POS_INV   = FPOS_BITS'(2);
    localparam logic [FPOS_BITS-1:0] POS_DATA  = FPOS_BITS'(3);
    localparam logic [FPOS_BITS-1:0] POS_SUM   = FPOS_BITS'(BLOCK_BYTES + 3);

    localparam logic [7:0] CHR_SOH  = 8'h01;
    localparam logic [7:0] CHR_EOT  = 8'h04;
    localparam logic [7:0] BYTE_ALL = 8'hff;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        REPLY_NONE = 2'd0,
        REPLY_ACK  = 2'd1,
        REPLY_NAK  = 2'd2
    } t_reply;

    typedef struct packed {
        logic [FPOS_BITS-1:0] fpos;
        logic [7:0]           exp_blk;
        logic [7:0]           sum;
        logic [ADDR_BITS-1:0] blk_addr;
        logic                 hdr_ok;
        logic                 done;
    } t_state;

    typedef struct packed {
        t_reply      reply;
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        finished;
    } t_result;

endpackage

// ===== sv/xmbr_if.sv =====
interface xmbr_rx_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface xmbr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reply;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        finished;

    modport source (output valid, output reply, output write_enable,
                    output write_address, output write_data, output finished,
                    input ready);
    modport sink   (input valid, input reply, input write_enable,
                    input write_address, input write_data, input finished,
                    output ready);
endinterface

interface xmbr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] base_address;

    modport source (output valid, output base_address, input ready);
    modport sink   (input valid, input base_address, output ready);
endinterface

// ===== sv/xmbr_step.sv =====
module xmbr_step (
    input  xmbr_pkg::t_state  i_state,
    input  logic              i_opcode,
    input  logic [7:0]        i_rx_byte,
    output xmbr_pkg::t_state  o_state,
    output xmbr_pkg::t_result o_result
);

    logic [xmbr_pkg::ADDR_BITS-1:0]    data_addr;
    logic [xmbr_pkg::ADDR_BITS+15:0]   data_addr_ext;
    logic                              at_start;
    logic                              in_data;

    assign at_start      = (i_state.fpos == xmbr_pkg::POS_START);
    assign in_data       = (i_state.fpos >= xmbr_pkg::POS_DATA) &&
                           (i_state.fpos < xmbr_pkg::POS_SUM);
    assign data_addr     = i_state.blk_addr +
                           xmbr_pkg::ADDR_BITS'(i_state.fpos - xmbr_pkg::POS_DATA);
    // widen before taking the low 16 bits so narrow address widths zero-extend
    assign data_addr_ext = {16'h0000, data_addr};

    always_comb begin
        o_state  = i_state;
        o_result = '{reply: xmbr_pkg::REPLY_NONE, write_enable: 1'b0,
                     write_address: 16'h0000, write_data: 8'h00, finished: 1'b0};

        if (i_state.done) begin
            // transfer over, beats are swallowed
        end else if (i_opcode == xmbr_pkg::OP_TIMEOUT) begin
            o_result.reply = at_start ? xmbr_pkg::REPLY_ACK : xmbr_pkg::REPLY_NAK;
            o_state.fpos   = xmbr_pkg::POS_START;
            o_state.sum    = 8'h00;
            o_state.hdr_ok = 1'b0;
        end else if (at_start) begin
            if (i_rx_byte == xmbr_pkg::CHR_EOT) begin
                o_result.reply    = xmbr_pkg::REPLY_ACK;
                o_result.finished = 1'b1;
                o_state.done      = 1'b1;
            end else begin
                o_state.hdr_ok = (i_rx_byte == xmbr_pkg::CHR_SOH);
                o_state.sum    = 8'h00;
                o_state.fpos   = xmbr_pkg::POS_NUM;
            end
        end else if (i_state.fpos == xmbr_pkg::POS_NUM) begin
            o_state.hdr_ok = i_state.hdr_ok && (i_rx_byte == i_state.exp_blk);
            o_state.fpos   = xmbr_pkg::POS_INV;
        end else if (i_state.fpos == xmbr_pkg::POS_INV) begin
            o_state.hdr_ok = i_state.hdr_ok &&
                             (i_rx_byte == (xmbr_pkg::BYTE_ALL ^ i_state.exp_blk));
            o_state.fpos   = xmbr_pkg::POS_DATA;
        end else if (in_data) begin
            o_state.sum  = i_state.sum + i_rx_byte;
            o_state.fpos = i_state.fpos + xmbr_pkg::FPOS_BITS'(1);
            if (i_state.hdr_ok) begin
                o_result.write_enable  = 1'b1;
                o_result.write_address = data_addr_ext[15:0];
                o_result.write_data    = i_rx_byte;
            end
        end else begin
            if (i_state.hdr_ok && (i_rx_byte == i_state.sum)) begin
                o_result.reply   = xmbr_pkg::REPLY_ACK;
                o_state.exp_blk  = i_state.exp_blk + 8'd1;
                o_state.blk_addr = i_state.blk_addr +
                                   xmbr_pkg::ADDR_BITS'(xmbr_pkg::BLOCK_BYTES);
            end else begin
                o_result.reply = xmbr_pkg::REPLY_NAK;
            end
            o_state.fpos   = xmbr_pkg::POS_START;
            o_state.sum    = 8'h00;
            o_state.hdr_ok = 1'b0;
        end
    end

endmodule

// ===== sv/xmodem_block_receiver_core.sv =====
// channel | dir | handshake   | payload
// i_rx    | in  | valid/ready | opcode, rx_byte
// o_res   | out | valid/ready | reply, write_enable, write_address, write_data, finished
// i_cfg   | in  | valid/ready | base_address (ready while no beat waits in the input register)
//
// One beat per cycle sustained while o_res takes results; a beat taken into the
// input register passes through the frame logic into the result register.
// Synchronous active-low reset: block counter 1, write pointer 0, frame empty.
// A stalled result holds in o_res; i_rx keeps taking a beat while the input
// register is empty or moves on in the same cycle.
module xmodem_block_receiver_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    xmbr_rx_if.sink         i_rx,
    xmbr_res_if.source      o_res,
    xmbr_cfg_if.sink        i_cfg
);

    logic                            r_in_valid;
    logic                            r_in_op;
    logic [7:0]                      r_in_byte;
    logic                            r_out_valid;
    xmbr_pkg::t_result               r_out;
    xmbr_pkg::t_state                r_state;
    xmbr_pkg::t_state                n_state;
    xmbr_pkg::t_result               n_out;
    logic                            out_free;
    logic                            adv;
    logic                            rx_acc;
    logic [xmbr_pkg::ADDR_BITS+15:0] cfg_ext;

    assign out_free    = !r_out_valid || o_res.ready;
    assign adv         = r_in_valid && out_free;
    assign i_rx.ready  = !r_in_valid || out_free;
    assign rx_acc      = i_rx.valid && i_rx.ready;
    // a waiting beat must update the frame state before the pointer reloads
    assign i_cfg.ready = !r_in_valid;
    assign cfg_ext     = {xmbr_pkg::ADDR_BITS'(0), i_cfg.base_address};

    xmbr_step u_step (
        .i_state   (r_state),
        .i_opcode  (r_in_op),
        .i_rx_byte (r_in_byte),
        .o_state   (n_state),
        .o_result  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_state.fpos     <= xmbr_pkg::POS_START;
            r_state.exp_blk  <= 8'd1;
            r_state.sum      <= 8'h00;
            r_state.blk_addr <= '0;
            r_state.hdr_ok   <= 1'b0;
            r_state.done     <= 1'b0;
        end else begin
            if (rx_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end

            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            // config is only taken while no beat waits in the input register; it restarts the write pointer
            if (i_cfg.valid && i_cfg.ready) begin
                r_state.blk_addr <= cfg_ext[xmbr_pkg::ADDR_BITS-1:0];
            end else if (adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_acc) begin
            r_in_op   <= i_rx.opcode;
            r_in_byte <= i_rx.rx_byte;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.reply         = r_out.reply;
    assign o_res.write_enable  = r_out.write_enable;
    assign o_res.write_address = r_out.write_address;
    assign o_res.write_data    = r_out.write_data;
    assign o_res.finished      = r_out.finished;

endmodule

// ===== dv/xmbr_checker.sv =====
`timescale 1ns / 1ps

module xmbr_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    xmbr_rx_if   rx,
    xmbr_res_if  res,
    xmbr_cfg_if  cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_beats_in,
    output int   o_acks,
    output int   o_naks,
    output int   o_writes
);

    // receiver state as predicted
    logic [xmbr_pkg::FPOS_BITS-1:0] fpos;
    logic [7:0]                     blk_no;
    logic [7:0]                     data_sum;
    logic [xmbr_pkg::ADDR_BITS-1:0] blk_addr;
    logic                           hdr_good;
    logic                           xfer_done;

    xmbr_pkg::t_result replies_due[$];

    function automatic void drop_frame();
        fpos     = xmbr_pkg::POS_START;
        data_sum = 8'h00;
        hdr_good = 1'b0;
    endfunction

    function automatic xmbr_pkg::t_result receiver_step(input logic op,
                                                        input logic [7:0] b);
        xmbr_pkg::t_result r;
        r       = '0;
        r.reply = xmbr_pkg::REPLY_NONE;
        if (xfer_done) begin
            // everything ignored until reset
        end else if (op == xmbr_pkg::OP_TIMEOUT) begin
            r.reply = (fpos == xmbr_pkg::POS_START) ? xmbr_pkg::REPLY_ACK
                                                    : xmbr_pkg::REPLY_NAK;
            drop_frame();
        end else if (fpos == xmbr_pkg::POS_START) begin
            if (b == xmbr_pkg::CHR_EOT) begin
                r.reply    = xmbr_pkg::REPLY_ACK;
                r.finished = 1'b1;
                xfer_done  = 1'b1;
            end else begin
                hdr_good = (b == xmbr_pkg::CHR_SOH);
                data_sum = 8'h00;
                fpos     = xmbr_pkg::POS_NUM;
            end
        end else if (fpos == xmbr_pkg::POS_NUM) begin
            hdr_good = hdr_good && (b == blk_no);
            fpos     = xmbr_pkg::POS_INV;
        end else if (fpos == xmbr_pkg::POS_INV) begin
            hdr_good = hdr_good && (b == (xmbr_pkg::BYTE_ALL ^ blk_no));
            fpos     = xmbr_pkg::POS_DATA;
        end else if (fpos != xmbr_pkg::POS_SUM) begin
            data_sum = data_sum + b;
            if (hdr_good) begin
                r.write_enable  = 1'b1;
                r.write_address = 16'(blk_addr +
                                      xmbr_pkg::ADDR_BITS'(fpos - xmbr_pkg::POS_DATA));
                r.write_data    = b;
            end
            fpos = fpos + 1'b1;
        end else begin
            if (hdr_good && b == data_sum) begin
                r.reply  = xmbr_pkg::REPLY_ACK;
                blk_no   = blk_no + 8'd1;
                blk_addr = blk_addr + xmbr_pkg::ADDR_BITS'(xmbr_pkg::BLOCK_BYTES);
            end else begin
                r.reply = xmbr_pkg::REPLY_NAK;
            end
            drop_frame();
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        xmbr_pkg::t_result want;
        xmbr_pkg::t_result got;
        if (!i_rst_n) begin
            blk_no    = 8'd1;
            blk_addr  = '0;
            xfer_done = 1'b0;
            drop_frame();
            replies_due.delete();
            o_fail_count = 0;
            o_beats_in   = 0;
            o_acks       = 0;
            o_naks       = 0;
            o_writes     = 0;
        end else begin
            // results first: a beat taken at this edge cannot answer yet
            if (res.valid && res.ready) begin
                got.reply         = xmbr_pkg::t_reply'(res.reply);
                got.write_enable  = res.write_enable;
                got.write_address = res.write_address;
                got.write_data    = res.write_data;
                got.finished      = res.finished;
                if (replies_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result beat with nothing expected: reply %0d we %0b",
                                 $realtime, got.reply, got.write_enable);
                end else begin
                    want = replies_due.pop_front();
                    if (got.reply !== want.reply
                            || got.write_enable !== want.write_enable
                            || got.write_address !== want.write_address
                            || got.write_data !== want.write_data
                            || got.finished !== want.finished) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch exp reply %0d we %0b addr %h data %h fin %0b",
                                     $realtime, want.reply, want.write_enable,
                                     want.write_address, want.write_data, want.finished);
                            $display("%0t:          got reply %0d we %0b addr %h data %h fin %0b",
                                     $realtime, got.reply, got.write_enable,
                                     got.write_address, got.write_data, got.finished);
                        end
                    end
                    if (want.reply == xmbr_pkg::REPLY_ACK) o_acks++;
                    if (want.reply == xmbr_pkg::REPLY_NAK) o_naks++;
                    if (want.write_enable) o_writes++;
                end
            end
            if (cfg.valid && cfg.ready)
                blk_addr = xmbr_pkg::ADDR_BITS'(cfg.base_address);
            if (rx.valid && rx.ready) begin
                replies_due.push_back(receiver_step(rx.opcode, rx.rx_byte));
                o_beats_in++;
            end
        end
        o_pending <= replies_due.size();
    end

endmodule

// ===== dv/tb_xmodem_block_receiver_core.sv =====
`timescale 1ns / 1ps

module tb_xmodem_block_receiver_core;

    typedef enum {
        FR_GOOD,
        FR_BAD_LEAD,
        FR_BAD_NUM,
        FR_BAD_INV,
        FR_BAD_SUM,
        FR_RESEND,
        FR_CUT
    } t_frame_kind;

    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;

    xmbr_rx_if  rx_if ();
    xmbr_res_if res_if ();
    xmbr_cfg_if cfg_if ();

    int fail_count;
    int pending;
    int beats_in;
    int acks;
    int naks;
    int writes;

    int         items_sent  = 0;
    int         good_frames = 0;
    int         frame_at    = 0;   // sender's view of the frame position
    logic [7:0] next_blk    = 8'd1;
    bit         quiet       = 1'b0;
    bit         hold_req    = 1'b0;

    xmodem_block_receiver_core uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    xmbr_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .rx           (rx_if),
        .res          (res_if),
        .cfg          (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_beats_in   (beats_in),
        .o_acks       (acks),
        .o_naks       (naks),
        .o_writes     (writes)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("timeout waiting for the receiver");
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                res_if.ready <= 1'b1;
            end else if (quiet) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        if (!quiet && $urandom_range(0, 99) < 10) begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.opcode  <= op;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        items_sent++;
        if (op == xmbr_pkg::OP_TIMEOUT)
            frame_at = 0;
        else if (frame_at == 0)
            frame_at = (b == xmbr_pkg::CHR_EOT) ? 0 : 1;
        else if (frame_at == xmbr_pkg::BLOCK_BYTES + 3)
            frame_at = 0;
        else
            frame_at++;
    endtask

    // wait until every result is back, then let the pipeline drain
    task automatic settle();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_base(input logic [15:0] addr);
        cfg_if.valid        <= 1'b1;
        cfg_if.base_address <= addr;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] data_byte();
        case ($urandom_range(0, 9))
            0:       return xmbr_pkg::CHR_EOT;
            1:       return xmbr_pkg::CHR_SOH;
            2:       return 8'h00;
            3:       return xmbr_pkg::BYTE_ALL;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_frame(input t_frame_kind kind);
        logic [7:0] lead;
        logic [7:0] num;
        logic [7:0] inv;
        logic [7:0] csum;
        logic [7:0] b;
        int         cut_at;
        if (frame_at != 0) send_item(xmbr_pkg::OP_TIMEOUT, 8'($urandom));
        lead   = xmbr_pkg::CHR_SOH;
        num    = next_blk;
        inv    = xmbr_pkg::BYTE_ALL ^ next_blk;
        csum   = 8'h00;
        cut_at = -1;
        case (kind)
            FR_BAD_LEAD: begin
                do lead = 8'($urandom);
                while (lead == xmbr_pkg::CHR_SOH || lead == xmbr_pkg::CHR_EOT);
            end
            FR_BAD_NUM: begin
                num = next_blk + 8'($urandom_range(1, 255));
                inv = xmbr_pkg::BYTE_ALL ^ num;
            end
            FR_BAD_INV: inv = inv ^ 8'($urandom_range(1, 255));
            FR_RESEND: begin
                num = next_blk - 8'd1;
                inv = xmbr_pkg::BYTE_ALL ^ num;
            end
            FR_CUT: cut_at = $urandom_range(1, xmbr_pkg::BLOCK_BYTES + 3);
            default: ;
        endcase
        for (int pos = 0; pos <= xmbr_pkg::BLOCK_BYTES + 3; pos++) begin
            if (pos == cut_at) begin
                send_item(xmbr_pkg::OP_TIMEOUT, 8'($urandom));
                return;
            end
            if (pos == 0) begin
                b = lead;
            end else if (pos == 1) begin
                b = num;
            end else if (pos == 2) begin
                b = inv;
            end else if (pos < xmbr_pkg::BLOCK_BYTES + 3) begin
                b    = data_byte();
                csum = csum + b;
            end else begin
                b = (kind == FR_BAD_SUM) ? csum ^ 8'($urandom_range(1, 255)) : csum;
            end
            send_item(xmbr_pkg::OP_BYTE, b);
        end
        if (kind == FR_GOOD) begin
            next_blk = next_blk + 8'd1;
            good_frames++;
        end
    endtask

    // stray bytes and timeouts; no EOT where it would end the transfer
    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(1, 6)) begin
            do b = 8'($urandom); while (frame_at == 0 && b == xmbr_pkg::CHR_EOT);
            if ($urandom_range(0, 5) == 0)
                send_item(xmbr_pkg::OP_TIMEOUT, b);
            else
                send_item(xmbr_pkg::OP_BYTE, b);
        end
    endtask

    function automatic t_frame_kind pick_kind(input int good_pct);
        if ($urandom_range(0, 99) < good_pct)
            return FR_GOOD;
        return t_frame_kind'($urandom_range(1, 6));
    endfunction

    task automatic run_mix(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < 25)
                send_noise();
            else
                send_frame(pick_kind(60));
        end
    endtask

    initial begin
        rst_n               <= 1'b0;
        rx_if.valid         <= 1'b0;
        rx_if.opcode        <= xmbr_pkg::OP_BYTE;
        rx_if.rx_byte       <= 8'h00;
        cfg_if.valid        <= 1'b0;
        cfg_if.base_address <= 16'h0000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty timeout, bad lead byte, timeouts at each header position
        send_item(xmbr_pkg::OP_TIMEOUT, xmbr_pkg::BYTE_ALL);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::BYTE_ALL);
        send_item(xmbr_pkg::OP_TIMEOUT, 8'h00);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::CHR_SOH);
        send_item(xmbr_pkg::OP_TIMEOUT, 8'h55);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::CHR_SOH);
        send_item(xmbr_pkg::OP_BYTE, next_blk);
        send_item(xmbr_pkg::OP_TIMEOUT, 8'haa);
        // good header, a few writes (EOT as data), cut mid-data
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::CHR_SOH);
        send_item(xmbr_pkg::OP_BYTE, next_blk);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::BYTE_ALL ^ next_blk);
        send_item(xmbr_pkg::OP_BYTE, 8'h00);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::BYTE_ALL);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::CHR_EOT);
        send_item(xmbr_pkg::OP_TIMEOUT, 8'h00);
        // bad lead with a good-looking header: no writes
        send_item(xmbr_pkg::OP_BYTE, 8'h00);
        send_item(xmbr_pkg::OP_BYTE, next_blk);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::BYTE_ALL ^ next_blk);
        send_item(xmbr_pkg::OP_BYTE, 8'h80);
        send_item(xmbr_pkg::OP_TIMEOUT, 8'h00);
        settle();

        // addresses wrap inside the first block; result side held off once
        set_base(16'hffc0);
        hold_req = 1'b1;
        send_frame(FR_GOOD);
        run_mix(350);
        settle();

        // no idling on either side for this stretch
        set_base(16'hffff);
        quiet = 1'b1;
        run_mix(300);
        quiet = 1'b0;
        settle();

        set_base(16'h0000);
        run_mix(450);
        settle();

        set_base(16'($urandom));
        run_mix(250);

        // close the transfer; everything after is ignored
        if (frame_at != 0) send_item(xmbr_pkg::OP_TIMEOUT, 8'h00);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::CHR_EOT);
        send_item(xmbr_pkg::OP_TIMEOUT, 8'h00);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::CHR_SOH);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::CHR_EOT);
        send_item(xmbr_pkg::OP_BYTE, xmbr_pkg::BYTE_ALL);
        send_item(xmbr_pkg::OP_TIMEOUT, xmbr_pkg::BYTE_ALL);
        settle();
        repeat (10) @(posedge clk);

        $display("receiver run: %0d beats in, %0d ACK, %0d NAK, %0d data writes",
                 beats_in, acks, naks, writes);
        $display("%0d good frames over 4 base settings, address wrap at the top, EOT closed",
                 good_frames);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
